// ----- hdl/round_robin_process_scheduler_defines.svh -----
// Assertion macros used by the scheduler controller RTL.
`ifndef ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_PROCESS_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define RRPS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rrps assertion failed");
// Condition in one cycle implies a consequence in the next.
`define RRPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrps assertion failed");
`else
`define RRPS_ASSERT(label, clk, rst, prop)
`define RRPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/rrps_pkg.sv -----
// Types, codes and helpers of the round-robin process scheduler.
package rrps_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int CNT_W     = 16;
   localparam int TIME_W    = 32;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_TICK = 2'd1,
      OP_EXIT = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_NEW        = 3'd0,
      ST_RUNNING    = 3'd1,
      ST_READY      = 3'd3,
      ST_TERMINATED = 3'd4
   } task_state_type;

   typedef enum logic [1:0] {
      FLT_OK   = 2'd0,
      FLT_FULL = 2'd1,
      FLT_SLOT = 2'd2
   } fault_type;

   typedef enum logic [1:0] {
      SCH_IDLE,
      SCH_EXEC,
      SCH_SCAN
   } sched_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_ROTATE,
      CELL_APPEND,
      CELL_CHARGE,
      CELL_EXIT
   } cell_op_type;

   // One queue entry: slot id plus the bookkeeping of that slot.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      task_state_type    state;
      logic [CNT_W-1:0]  interrupts;
      logic [CNT_W-1:0]  switches;
      logic [TIME_W-1:0] start;
   } cell_data_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      cell_op_type        op;
      logic [COUNT_W-1:0] count;
      logic [SLOT_W-1:0]  target;
      cell_data_type      tail;
   } cell_cmd_type;

   // What the row reports back to the controller.
   typedef struct packed {
      logic          hit;
      cell_data_type hit_data;
      cell_data_type head;
   } row_status_type;

   typedef struct packed {
      logic [SLOT_W-1:0] run_slot;
      logic              idle_runs;
      logic              start_new;
      logic              resumed;
      logic [SLOT_W-1:0] added_slot;
      logic [CNT_W-1:0]  exit_interrupts;
      logic [CNT_W-1:0]  exit_switches;
      logic [TIME_W-1:0] exit_elapsed;
      fault_type         fault;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

// ----- hdl/rrps_cell.sv -----
// One queue cell: holds a slot entry and shifts it toward the head on rotate.
module rrps_cell (
   input  logic                         clock,
   input  logic [rrps_pkg::SLOT_W-1:0]  pos,
   input  rrps_pkg::cell_cmd_type       cmd,
   input  rrps_pkg::cell_data_type      right,
   output rrps_pkg::cell_data_type      data,
   output logic                         hit
);

   rrps_pkg::cell_data_type            data_ff;
   rrps_pkg::cell_data_type            data_in;
   logic [rrps_pkg::COUNT_W-1:0]       pos_ext;
   logic                               in_use;

   assign pos_ext = rrps_pkg::COUNT_W'(pos);
   assign in_use  = pos_ext < cmd.count;
   assign hit     = in_use && (data_ff.slot == cmd.target);
   assign data    = data_ff;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         rrps_pkg::CELL_HOLD: begin
         end
         rrps_pkg::CELL_ROTATE: begin
            // last live entry takes the (updated) head, the rest shift left
            if (pos_ext == cmd.count - 1'b1) begin
               data_in = cmd.tail;
            end else if (in_use) begin
               data_in = right;
            end
         end
         rrps_pkg::CELL_APPEND: begin
            if (pos_ext == cmd.count) begin
               data_in.slot  = pos;
               data_in.state = rrps_pkg::ST_NEW;
            end
         end
         rrps_pkg::CELL_CHARGE: begin
            if (hit) begin
               data_in.interrupts = rrps_pkg::sat_inc(data_ff.interrupts);
               data_in.state      = rrps_pkg::ST_READY;
            end
         end
         rrps_pkg::CELL_EXIT: begin
            if (hit) begin
               data_in.state = rrps_pkg::ST_TERMINATED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

// ----- hdl/rrps_ctrl.sv -----
// Scheduler control: item sequencing, global counters and result register.
`include "round_robin_process_scheduler_defines.svh"

module rrps_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [rrps_pkg::SLOT_W-1:0]  req_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output rrps_pkg::rsp_type            rsp,
   output rrps_pkg::cell_cmd_type       cmd,
   input  rrps_pkg::row_status_type     row
);

   rrps_pkg::sched_state_type          state_ff, state_in;
   rrps_pkg::op_type                   op_ff, op_in;
   logic [rrps_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [rrps_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [rrps_pkg::SLOT_W-1:0]        cur_ff, cur_in;
   logic                               idle_ff, idle_in;
   logic [rrps_pkg::CNT_W-1:0]         idle_intr_ff, idle_intr_in;
   logic [rrps_pkg::TIME_W-1:0]        tick_ff, tick_in;
   logic [rrps_pkg::SLOT_W-1:0]        scan_k_ff, scan_k_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   rrps_pkg::rsp_type                  rsp_ff, rsp_in;
   rrps_pkg::cell_data_type            tail;
   logic                               found;
   logic                               out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != rrps_pkg::SCH_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // head entry as it goes back to the tail of the queue
   always_comb begin
      tail  = row.head;
      found = 1'b0;
      if (row.head.state == rrps_pkg::ST_NEW) begin
         found           = 1'b1;
         tail.state      = rrps_pkg::ST_RUNNING;
         tail.interrupts = '0;
         tail.switches   = '0;
         tail.start      = tick_ff;
      end else if (row.head.state == rrps_pkg::ST_READY) begin
         found      = 1'b1;
         tail.state = rrps_pkg::ST_RUNNING;
         if (idle_ff || (cur_ff != row.head.slot)) begin
            tail.switches = rrps_pkg::sat_inc(row.head.switches);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      idle_in      = idle_ff;
      idle_intr_in = idle_intr_ff;
      tick_in      = tick_ff;
      scan_k_in    = scan_k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = rrps_pkg::CELL_HOLD;
      cmd.count    = count_ff;
      cmd.target   = slot_ff;
      cmd.tail     = tail;

      unique case (state_ff)
         rrps_pkg::SCH_IDLE: begin
            if (req_valid) begin
               op_in    = rrps_pkg::op_type'(req_op);
               slot_in  = req_slot;
               state_in = rrps_pkg::SCH_EXEC;
            end
         end
         rrps_pkg::SCH_EXEC: begin
            if (out_free) begin
               rsp_in           = '0;
               rsp_in.run_slot  = idle_ff ? '0 : cur_ff;
               rsp_in.idle_runs = idle_ff;
               rsp_in.fault     = rrps_pkg::FLT_OK;
               unique case (op_ff)
                  rrps_pkg::OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     state_in     = rrps_pkg::SCH_IDLE;
                     if (count_ff == rrps_pkg::COUNT_W'(rrps_pkg::NUM_SLOTS)) begin
                        rsp_in.fault = rrps_pkg::FLT_FULL;
                     end else begin
                        cmd.op            = rrps_pkg::CELL_APPEND;
                        rsp_in.added_slot = rrps_pkg::SLOT_W'(count_ff);
                        count_in          = count_ff + 1'b1;
                     end
                  end
                  rrps_pkg::OP_TICK: begin
                     tick_in = tick_ff + 1'b1;
                     if (idle_ff) begin
                        idle_intr_in = rrps_pkg::sat_inc(idle_intr_ff);
                     end else begin
                        cmd.op     = rrps_pkg::CELL_CHARGE;
                        cmd.target = cur_ff;
                     end
                     if (count_ff == '0) begin
                        idle_in          = 1'b1;
                        cur_in           = '0;
                        rsp_in.run_slot  = '0;
                        rsp_in.idle_runs = 1'b1;
                        rsp_valid_in     = 1'b1;
                        state_in         = rrps_pkg::SCH_IDLE;
                     end else begin
                        scan_k_in = '0;
                        state_in  = rrps_pkg::SCH_SCAN;
                     end
                  end
                  rrps_pkg::OP_EXIT: begin
                     idle_in          = 1'b1;
                     cur_in           = '0;
                     rsp_in.run_slot  = '0;
                     rsp_in.idle_runs = 1'b1;
                     rsp_valid_in     = 1'b1;
                     state_in         = rrps_pkg::SCH_IDLE;
                     if ((rrps_pkg::COUNT_W'(slot_ff) >= count_ff) ||
                         (row.hit_data.state == rrps_pkg::ST_NEW)) begin
                        rsp_in.fault = rrps_pkg::FLT_SLOT;
                     end else begin
                        cmd.op                 = rrps_pkg::CELL_EXIT;
                        rsp_in.exit_interrupts = row.hit_data.interrupts;
                        rsp_in.exit_switches   = row.hit_data.switches;
                        rsp_in.exit_elapsed    = tick_ff - row.hit_data.start;
                     end
                  end
                  rrps_pkg::OP_NONE: begin
                     rsp_valid_in = 1'b1;
                     state_in     = rrps_pkg::SCH_IDLE;
                  end
                  default: begin
                     state_in = rrps_pkg::SCH_IDLE;
                  end
               endcase
            end
         end
         rrps_pkg::SCH_SCAN: begin
            // one queue entry per cycle: look at the head, rotate it to the tail
            cmd.op = rrps_pkg::CELL_ROTATE;
            if (found) begin
               idle_in          = 1'b0;
               cur_in           = row.head.slot;
               rsp_in.run_slot  = row.head.slot;
               rsp_in.idle_runs = 1'b0;
               rsp_in.start_new = row.head.state == rrps_pkg::ST_NEW;
               rsp_in.resumed   = row.head.state == rrps_pkg::ST_READY;
               rsp_valid_in     = 1'b1;
               state_in         = rrps_pkg::SCH_IDLE;
            end else if (rrps_pkg::COUNT_W'(scan_k_ff) == count_ff - 1'b1) begin
               idle_in          = 1'b1;
               cur_in           = '0;
               rsp_in.run_slot  = '0;
               rsp_in.idle_runs = 1'b1;
               rsp_valid_in     = 1'b1;
               state_in         = rrps_pkg::SCH_IDLE;
            end else begin
               scan_k_in = scan_k_ff + 1'b1;
            end
         end
         default: begin
            state_in = rrps_pkg::SCH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrps_pkg::SCH_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         idle_ff      <= 1'b1;
         idle_intr_ff <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         idle_ff      <= idle_in;
         idle_intr_ff <= idle_intr_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      slot_ff   <= slot_in;
      scan_k_ff <= scan_k_in;
      rsp_ff    <= rsp_in;
   end

   `RRPS_ASSERT(a_idle_slot_zero, clock, reset, !idle_ff || (cur_ff == '0))
   `RRPS_ASSERT(a_count_bound, clock, reset, count_ff <= rrps_pkg::COUNT_W'(rrps_pkg::NUM_SLOTS))
   `RRPS_ASSERT(a_scan_no_rsp, clock, reset, (state_ff != rrps_pkg::SCH_SCAN) || !rsp_valid_ff)
   `RRPS_ASSERT(a_scan_in_range, clock, reset, (state_ff != rrps_pkg::SCH_SCAN) || (rrps_pkg::COUNT_W'(scan_k_ff) < count_ff))
   `RRPS_ASSERT_NEXT(a_tick_advance, clock, reset, (state_ff == rrps_pkg::SCH_EXEC) && (op_ff == rrps_pkg::OP_TICK) && out_free, tick_ff == $past(tick_ff) + 1'b1)

endmodule

// ----- hdl/round_robin_process_scheduler.sv -----
// Top level of the round-robin process scheduler: cell row and controller.
//
// Usage:
//   Requests arrive on req_* (req_op: add, timer tick, exit; req_slot for exit).
//   A transfer happens at a clock edge with req_valid high and req_stall low.
//   Every request yields exactly one result on rsp_*, transferred at an edge
//   with rsp_valid high and rsp_stall low; results keep request order.
// Sequencing:
//   Add, exit, unknown ops and a tick on an empty table: the request waits in
//   state EXEC and its result is registered once the output register is free.
//   Timer tick: from EXEC the controller goes to SCAN and examines 1 to 16
//   queue entries before the result is registered, walking the row of slot
//   cells one entry per cycle and rotating the head to the tail. One request
//   is worked on at a time; req_stall drops as the result loads.
// Stalls:
//   A finished result sits in the output register while rsp_stall is high;
//   the next request is still taken and held until that register frees up.
// Reset (synchronous, active high): empty table, idle task running, time and
//   idle counters zero. Slot entries hold no reset value and are only read
//   once written.
module round_robin_process_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [rrps_pkg::SLOT_W-1:0]  req_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [rrps_pkg::SLOT_W-1:0]  rsp_run_slot,
   output logic                         rsp_idle_runs,
   output logic                         rsp_start_new,
   output logic                         rsp_resumed,
   output logic [rrps_pkg::SLOT_W-1:0]  rsp_added_slot,
   output logic [rrps_pkg::CNT_W-1:0]   rsp_exit_interrupts,
   output logic [rrps_pkg::CNT_W-1:0]   rsp_exit_switches,
   output logic [rrps_pkg::TIME_W-1:0]  rsp_exit_elapsed,
   output logic [1:0]                   rsp_fault
);

   rrps_pkg::cell_cmd_type             cmd;
   rrps_pkg::row_status_type           row;
   rrps_pkg::rsp_type                  rsp;
   rrps_pkg::cell_data_type            cell_data  [rrps_pkg::NUM_SLOTS];
   rrps_pkg::cell_data_type            right_data [rrps_pkg::NUM_SLOTS];
   logic [rrps_pkg::NUM_SLOTS-1:0]     cell_hit;

   // Row of cells; cell 0 is the head of the run queue. Each cell sees its
   // right neighbor, which it takes over on a rotate.
   for (genvar i = 0; i < rrps_pkg::NUM_SLOTS; i++) begin : g_cell
      if (i < rrps_pkg::NUM_SLOTS - 1) begin : g_mid
         assign right_data[i] = cell_data[i+1];
      end else begin : g_end
         assign right_data[i] = cell_data[i];
      end

      rrps_cell u_cell (
         .clock (clock),
         .pos   (rrps_pkg::SLOT_W'(i)),
         .cmd   (cmd),
         .right (right_data[i]),
         .data  (cell_data[i]),
         .hit   (cell_hit[i])
      );
   end

   // At most one live cell carries a given slot id, so an OR picks it out.
   always_comb begin
      row.hit_data = '0;
      for (int i = 0; i < rrps_pkg::NUM_SLOTS; i++) begin
         if (cell_hit[i]) begin
            row.hit_data = row.hit_data | cell_data[i];
         end
      end
      row.hit  = |cell_hit;
      row.head = cell_data[0];
   end

   rrps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .req_slot  (req_slot),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .cmd       (cmd),
      .row       (row)
   );

   assign rsp_run_slot        = rsp.run_slot;
   assign rsp_idle_runs       = rsp.idle_runs;
   assign rsp_start_new       = rsp.start_new;
   assign rsp_resumed         = rsp.resumed;
   assign rsp_added_slot      = rsp.added_slot;
   assign rsp_exit_interrupts = rsp.exit_interrupts;
   assign rsp_exit_switches   = rsp.exit_switches;
   assign rsp_exit_elapsed    = rsp.exit_elapsed;
   assign rsp_fault           = rsp.fault;

endmodule
